[rtl/core/metric_text_number_classifier_assert.svh]
// assertion macros used by the top rtl file
`ifndef METRIC_TEXT_NUMBER_CLASSIFIER_ASSERT_SVH
`define METRIC_TEXT_NUMBER_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define MTNC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication
`define MTNC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

[rtl/core/mtnc_pkg.sv]
`timescale 1ns / 1ps
package mtnc_pkg;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_TOKEN,
    PH_TRAIL,
    PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    G_START,
    G_SIGNED,
    G_ZERO,
    G_INT,
    G_DOT,
    G_FRAC,
    G_EXP,
    G_EXP_SIGN,
    G_EXP_DIG,
    G_FAIL
  } gram_t;

  typedef struct packed {
    phase_t      phase;
    gram_t       gram;
    logic        pct_pending;
    logic [1:0]  tok_len;
    logic [63:0] acc;
    logic        ovf;
    logic        neg_seen;
    logic        trail_dig;
  } scan_state_t;

  localparam scan_state_t ST_RESET = '{
    phase:       PH_LEAD,
    gram:        G_START,
    pct_pending: 1'b0,
    tok_len:     2'd0,
    acc:         64'd0,
    ovf:         1'b0,
    neg_seen:    1'b0,
    trail_dig:   1'b0
  };

  localparam logic [1:0] KIND_STRING   = 2'd0;
  localparam logic [1:0] KIND_SIGNED   = 2'd1;
  localparam logic [1:0] KIND_UNSIGNED = 2'd2;
  localparam logic [1:0] KIND_DECIMAL  = 2'd3;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_LOW_E   = 8'h65;
  localparam logic [7:0] CH_UP_E    = 8'h45;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_NUL     = 8'h00;

  localparam logic [63:0] ACC_LIMIT  = 64'd1844674407370955161;
  localparam logic [63:0] SIGNED_MAX = 64'h8000_0000_0000_0000;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

[rtl/core/mtnc_step.sv]
`timescale 1ns / 1ps
module mtnc_step (
  input  mtnc_pkg::scan_state_t st,
  input  logic [7:0]            text_char,
  output mtnc_pkg::scan_state_t st_next
);
  import mtnc_pkg::*;

  logic        dig;
  logic        ws;
  logic        tok;
  logic        do_gram;
  logic        do_acc;
  logic        set_neg;
  gram_t       g_new;
  logic [3:0]  d;
  logic [63:0] acc_mul;

  assign dig     = is_dig(text_char);
  assign ws      = is_ws(text_char);
  assign d       = text_char[3:0];
  assign acc_mul = {st.acc[60:0], 3'b000} + {st.acc[62:0], 1'b0} + {60'd0, d};

  // one grammar step for the current char
  always_comb begin
    g_new   = st.gram;
    do_acc  = 1'b0;
    set_neg = 1'b0;
    case (st.gram)
      G_START, G_SIGNED: begin
        if (st.gram == G_START && text_char == CH_MINUS) begin
          set_neg = 1'b1;
          g_new   = G_SIGNED;
        end else if (st.gram == G_START && text_char == CH_PLUS) begin
          g_new = G_SIGNED;
        end else if (text_char == CH_DOT) begin
          g_new = G_DOT;
        end else if (text_char == CH_ZERO) begin
          g_new = G_ZERO;
        end else if (text_char >= CH_ONE && text_char <= CH_NINE) begin
          g_new  = G_INT;
          do_acc = 1'b1;
        end else begin
          g_new = G_FAIL;
        end
      end
      G_ZERO:   g_new = (text_char == CH_DOT) ? G_DOT : G_FAIL;
      G_INT: begin
        if (dig) begin
          do_acc = 1'b1;
        end else begin
          g_new = (text_char == CH_DOT) ? G_DOT : G_FAIL;
        end
      end
      G_DOT:    g_new = dig ? G_FRAC : G_FAIL;
      G_FRAC: begin
        if (!dig) begin
          g_new = (text_char == CH_LOW_E || text_char == CH_UP_E) ? G_EXP : G_FAIL;
        end
      end
      G_EXP:    g_new = (text_char == CH_PLUS || text_char == CH_MINUS) ? G_EXP_SIGN : G_FAIL;
      G_EXP_SIGN: g_new = dig ? G_EXP_DIG : G_FAIL;
      G_EXP_DIG: begin
        if (!dig) begin
          g_new = G_FAIL;
        end
      end
      default:  g_new = G_FAIL;
    endcase
  end

  always_comb begin
    st_next = st;
    tok     = 1'b0;
    do_gram = 1'b0;
    if (st.phase != PH_DONE) begin
      if (text_char == CH_NUL) begin
        st_next.pct_pending = 1'b0;
        st_next.phase       = PH_DONE;
      end else if (st.phase == PH_LEAD) begin
        if (!ws) begin
          st_next.phase = PH_TOKEN;
          tok           = 1'b1;
        end
      end else if (st.phase == PH_TOKEN) begin
        if (ws) begin
          st_next.pct_pending = 1'b0;
          st_next.phase       = PH_TRAIL;
        end else begin
          tok = 1'b1;
        end
      end else if (dig) begin
        st_next.trail_dig = 1'b1;
      end
    end

    if (tok) begin
      if (st.pct_pending) begin
        // held percent was not the last token char, so the token fails
        st_next.gram        = G_FAIL;
        st_next.pct_pending = (text_char == CH_PERCENT);
      end else if (text_char == CH_PERCENT && st.tok_len != 2'd0) begin
        st_next.pct_pending = 1'b1;
      end else begin
        do_gram = 1'b1;
      end
      if (st.tok_len != 2'd3) begin
        st_next.tok_len = st.tok_len + 2'd1;
      end
    end

    if (do_gram) begin
      st_next.gram = g_new;
      if (set_neg) begin
        st_next.neg_seen = 1'b1;
      end
      if (do_acc && !st.ovf) begin
        if (st.acc > ACC_LIMIT || (st.acc == ACC_LIMIT && d > 4'd5)) begin
          st_next.ovf = 1'b1;
          st_next.acc = '1;
        end else begin
          st_next.acc = acc_mul;
        end
      end
    end
  end

endmodule

[rtl/core/mtnc_classify.sv]
`timescale 1ns / 1ps
module mtnc_classify (
  input  mtnc_pkg::scan_state_t st,
  output logic [1:0]            value_kind,
  output logic [63:0]           int_magnitude,
  output logic                  is_negative
);
  import mtnc_pkg::*;

  always_comb begin
    value_kind    = KIND_STRING;
    int_magnitude = 64'd0;
    is_negative   = 1'b0;
    if (!st.trail_dig) begin
      if (st.gram == G_ZERO || st.gram == G_INT) begin
        if (st.neg_seen) begin
          value_kind  = KIND_SIGNED;
          is_negative = 1'b1;
          if (st.ovf || st.acc > SIGNED_MAX) begin
            int_magnitude = SIGNED_MAX;
          end else begin
            int_magnitude = st.acc;
          end
        end else begin
          value_kind    = KIND_UNSIGNED;
          int_magnitude = st.ovf ? '1 : st.acc;
        end
      end else if (st.gram == G_FRAC || st.gram == G_EXP_DIG) begin
        value_kind = KIND_DECIMAL;
      end
    end
  end

endmodule

[rtl/core/metric_text_number_classifier.sv]
`timescale 1ns / 1ps
// channel   handshake                  payload
// text      text_valid / text_ready    text_char, is_last
// result    result_valid / result_ready value_kind, int_magnitude, is_negative
//
// one char per cycle while no last char waits; a result enters the result register
// when its last char leaves the input register
// the input register feeds one scan step per cycle into the scan state while it is not stalled
// synchronous reset clears the scan state and both valid flags
// a last char waits in the input register while an untaken result is held;
// other chars keep flowing
module metric_text_number_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_ready,
  input  logic [7:0]  text_char,
  input  logic        is_last,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  value_kind,
  output logic [63:0] int_magnitude,
  output logic        is_negative
);
  import mtnc_pkg::*;

  `include "metric_text_number_classifier_assert.svh"

  logic        s1_valid;
  logic [7:0]  s1_char;
  logic        s1_last;
  logic        out_free;
  logic        advance;
  scan_state_t st;
  scan_state_t st_next;
  logic [1:0]  kind_c;
  logic [63:0] mag_c;
  logic        neg_c;

  assign out_free   = !result_valid || result_ready;
  assign advance    = s1_valid && (!s1_last || out_free);
  assign text_ready = !s1_valid || advance;

  mtnc_step u_step (
    .st        (st),
    .text_char (s1_char),
    .st_next   (st_next)
  );

  mtnc_classify u_classify (
    .st            (st_next),
    .value_kind    (kind_c),
    .int_magnitude (mag_c),
    .is_negative   (neg_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      st           <= ST_RESET;
    end else begin
      if (text_ready) begin
        s1_valid <= text_valid;
      end
      if (advance) begin
        st <= s1_last ? ST_RESET : st_next;
      end
      if (advance && s1_last) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && text_ready) begin
      s1_char <= text_char;
      s1_last <= is_last;
    end
    if (advance && s1_last) begin
      value_kind    <= kind_c;
      int_magnitude <= mag_c;
      is_negative   <= neg_c;
    end
  end

  `MTNC_ASSERT_NOW(a_neg_only_signed, clk, rst,
    result_valid && is_negative, value_kind == KIND_SIGNED)
  `MTNC_ASSERT_NOW(a_mag_zero_non_int, clk, rst,
    result_valid && (value_kind == KIND_STRING || value_kind == KIND_DECIMAL),
    int_magnitude == 64'd0)
  `MTNC_ASSERT_NEXT(a_state_cleared, clk, rst,
    advance && s1_last, st == ST_RESET && result_valid)
  `MTNC_ASSERT_NOW(a_stall_cause, clk, rst,
    !text_ready, s1_valid && s1_last && result_valid && !result_ready)

endmodule

[tb/tb_metric_text_number_classifier.sv]
`timescale 1ns / 1ps
module tb_metric_text_number_classifier;
  import mtnc_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 200;
  // '#' in the table stands for a zero byte
  localparam logic [7:0] NUL_STAND_IN = 8'h23;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] mag;
    logic        neg;
  } value_rec_t;

  typedef struct {
    string       txt;
    logic        typed;
    logic [1:0]  kind;
    logic [63:0] mag;
    logic        neg;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic        text_ready;
  logic [7:0]  text_char = 8'd0;
  logic        is_last = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [1:0]  value_kind;
  logic [63:0] int_magnitude;
  logic        is_negative;

  scan_state_t scan = ST_RESET;
  value_rec_t  expected_values[$];
  value_rec_t  head;
  logic        gaps_on = 1'b1;
  logic        hold_req = 1'b0;
  int          errors = 0;
  int          chars_sent = 0;
  int          texts_sent = 0;
  int          results_seen = 0;
  int          kind_hits[4] = '{0, 0, 0, 0};
  int          cycle_count = 0;

  dir_row_t dir_rows[26] = '{
    '{"0", 1'b1, KIND_UNSIGNED, 64'd0, 1'b0},
    '{"-0", 1'b1, KIND_SIGNED, 64'd0, 1'b1},
    '{"18446744073709551615", 1'b1, KIND_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    '{"18446744073709551616", 1'b1, KIND_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    '{"-9223372036854775808", 1'b1, KIND_SIGNED, SIGNED_MAX, 1'b1},
    '{"-9223372036854775809", 1'b1, KIND_SIGNED, SIGNED_MAX, 1'b1},
    '{"+42", 1'b0, KIND_STRING, 64'd0, 1'b0},
    '{" \t\n7\r", 1'b0, KIND_STRING, 64'd0, 1'b0},
    '{"3.14", 1'b1, KIND_DECIMAL, 64'd0, 1'b0},
    '{"-.5e+10", 1'b0, KIND_STRING, 64'd0, 1'b0},
    '{"1.5E-3%", 1'b0, KIND_STRING, 64'd0, 1'b0},
    '{"%", 1'b1, KIND_STRING, 64'd0, 1'b0},
    '{"1%2", 1'b1, KIND_STRING, 64'd0, 1'b0},
    '{"12%%", 1'b0, KIND_STRING, 64'd0, 1'b0},
    '{"007", 1'b1, KIND_STRING, 64'd0, 1'b0},
    '{"1.0e5", 1'b1, KIND_STRING, 64'd0, 1'b0},
    '{"1.e+1", 1'b0, KIND_STRING, 64'd0, 1'b0},
    '{" ", 1'b1, KIND_STRING, 64'd0, 1'b0},
    '{"#", 1'b1, KIND_STRING, 64'd0, 1'b0},
    '{"12#34", 1'b0, KIND_STRING, 64'd0, 1'b0},
    '{"5 abc", 1'b0, KIND_STRING, 64'd0, 1'b0},
    '{"5 x9", 1'b1, KIND_STRING, 64'd0, 1'b0},
    '{"\2003", 1'b0, KIND_STRING, 64'd0, 1'b0},
    '{"\377", 1'b0, KIND_STRING, 64'd0, 1'b0},
    '{"\t12 %", 1'b0, KIND_STRING, 64'd0, 1'b0},
    '{"99%", 1'b0, KIND_STRING, 64'd0, 1'b0}
  };

  metric_text_number_classifier u_top (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_char    (text_char),
    .is_last      (is_last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .value_kind   (value_kind),
    .int_magnitude(int_magnitude),
    .is_negative  (is_negative)
  );

  always #2 clk = ~clk;

  function automatic logic blank_byte(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic void add_digit(input logic [7:0] c);
    logic [63:0] d;
    d = {56'd0, c - CH_ZERO};
    if (scan.ovf) return;
    if (scan.acc > ACC_LIMIT || (scan.acc == ACC_LIMIT && d > 64'd5)) begin
      scan.ovf = 1'b1;
      scan.acc = '1;
    end else begin
      scan.acc = scan.acc * 64'd10 + d;
    end
  endfunction

  function automatic void step_grammar(input logic [7:0] c);
    gram_t g;
    g = scan.gram;
    if (g == G_START) begin
      if (c == CH_MINUS) begin
        scan.neg_seen = 1'b1;
        scan.gram = G_SIGNED;
        return;
      end
      if (c == CH_PLUS) begin
        scan.gram = G_SIGNED;
        return;
      end
      g = G_SIGNED;
    end
    case (g)
      G_SIGNED: begin
        if (c == CH_DOT) scan.gram = G_DOT;
        else if (c == CH_ZERO) scan.gram = G_ZERO;
        else if (digit_byte(c)) begin
          scan.gram = G_INT;
          add_digit(c);
        end else scan.gram = G_FAIL;
      end
      G_ZERO: scan.gram = (c == CH_DOT) ? G_DOT : G_FAIL;
      G_INT: begin
        if (digit_byte(c)) add_digit(c);
        else scan.gram = (c == CH_DOT) ? G_DOT : G_FAIL;
      end
      G_DOT: scan.gram = digit_byte(c) ? G_FRAC : G_FAIL;
      G_FRAC: begin
        if (!digit_byte(c)) scan.gram = (c == CH_LOW_E || c == CH_UP_E) ? G_EXP : G_FAIL;
      end
      G_EXP: scan.gram = (c == CH_PLUS || c == CH_MINUS) ? G_EXP_SIGN : G_FAIL;
      G_EXP_SIGN: scan.gram = digit_byte(c) ? G_EXP_DIG : G_FAIL;
      G_EXP_DIG: begin
        if (!digit_byte(c)) scan.gram = G_FAIL;
      end
      default: scan.gram = G_FAIL;
    endcase
  endfunction

  function automatic void token_step(input logic [7:0] c);
    if (scan.pct_pending) begin
      scan.pct_pending = 1'b0;
      step_grammar(CH_PERCENT);
    end
    if (c == CH_PERCENT && scan.tok_len != 2'd0) scan.pct_pending = 1'b1;
    else step_grammar(c);
    if (scan.tok_len != 2'd3) scan.tok_len = scan.tok_len + 2'd1;
  endfunction

  function automatic logic classify_char(input logic [7:0] c, input logic fin,
                                         output value_rec_t r);
    r = '{KIND_STRING, 64'd0, 1'b0};
    if (scan.phase != PH_DONE) begin
      if (c == CH_NUL) begin
        scan.pct_pending = 1'b0;
        scan.phase = PH_DONE;
      end else if (scan.phase == PH_LEAD) begin
        if (!blank_byte(c)) begin
          scan.phase = PH_TOKEN;
          token_step(c);
        end
      end else if (scan.phase == PH_TOKEN) begin
        if (blank_byte(c)) begin
          scan.pct_pending = 1'b0;
          scan.phase = PH_TRAIL;
        end else begin
          token_step(c);
        end
      end else if (digit_byte(c)) begin
        scan.trail_dig = 1'b1;
      end
    end
    if (!fin) return 1'b0;
    if (!scan.trail_dig) begin
      if (scan.gram == G_ZERO || scan.gram == G_INT) begin
        if (scan.neg_seen) begin
          r.kind = KIND_SIGNED;
          r.neg = 1'b1;
          r.mag = (scan.ovf || scan.acc > SIGNED_MAX) ? SIGNED_MAX : scan.acc;
        end else begin
          r.kind = KIND_UNSIGNED;
          r.mag = scan.ovf ? '1 : scan.acc;
        end
      end else if (scan.gram == G_FRAC || scan.gram == G_EXP_DIG) begin
        r.kind = KIND_DECIMAL;
      end
    end
    scan = ST_RESET;
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(0, 1) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] pick_digit(input int lo);
    return 8'(CH_ZERO + $urandom_range(lo, 9));
  endfunction

  task automatic build_text(ref logic [7:0] t[$]);
    int shape;
    int n;
    t.delete();
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) t.push_back(pick_blank());
    shape = $urandom_range(0, 9);
    if (shape < 7 && $urandom_range(0, 3) == 0)
      t.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
    case (shape)
      0, 1, 2, 3: begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 5);
        t.push_back(($urandom_range(0, 9) == 0) ? CH_ZERO : pick_digit(1));
        repeat (n) t.push_back(pick_digit(0));
      end
      4, 5: begin
        case ($urandom_range(0, 2))
          0: t.push_back(CH_ZERO);
          1: repeat ($urandom_range(1, 4)) t.push_back(pick_digit(1));
          default: ;
        endcase
        t.push_back(CH_DOT);
        n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
        repeat (n) t.push_back(pick_digit(0));
        if ($urandom_range(0, 1)) begin
          t.push_back($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
          if ($urandom_range(0, 3) != 0) t.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
          repeat ($urandom_range(0, 3)) t.push_back(pick_digit(0));
        end
      end
      6: begin
        t.push_back(CH_ZERO);
        if ($urandom_range(0, 1)) t.push_back(pick_digit(0));
      end
      default: repeat ($urandom_range(1, 5)) t.push_back(8'($urandom_range(0, 255)));
    endcase
    if (shape < 7 && $urandom_range(0, 3) == 0) t.push_back(CH_PERCENT);
    if ($urandom_range(0, 3) == 0) begin
      t.push_back(pick_blank());
      repeat ($urandom_range(0, 3))
        t.push_back($urandom_range(0, 1) ? pick_digit(0) : 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0) t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
  endtask

  task automatic send_text(ref logic [7:0] t[$], input logic typed, input value_rec_t want);
    value_rec_t calc;
    logic       fin;
    for (int i = 0; i < t.size(); i++) begin
      fin = (i == t.size() - 1);
      if (gaps_on) begin
        while ($urandom_range(0, 99) < 34) begin
          text_valid <= 1'b0;
          @(negedge clk);
        end
      end
      text_valid <= 1'b1;
      text_char <= t[i];
      is_last <= fin;
      @(posedge clk);
      while (!text_ready) @(posedge clk);
      if (classify_char(t[i], fin, calc)) expected_values.push_back(typed ? want : calc);
      chars_sent++;
      @(negedge clk);
    end
    texts_sent++;
  endtask

  task automatic drain_results();
    text_valid <= 1'b0;
    @(negedge clk);
    while (expected_values.size() != 0) @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    errors++;
    $display("MISMATCH result %0d %s: expected %0h, got %0h", results_seen, what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_values.size() == 0) begin
        report_mismatch("arrived with nothing expected", 64'd0, {62'd0, value_kind});
      end else begin
        head = expected_values.pop_front();
        if (value_kind !== head.kind)
          report_mismatch("value_kind", {62'd0, head.kind}, {62'd0, value_kind});
        if (int_magnitude !== head.mag) report_mismatch("int_magnitude", head.mag, int_magnitude);
        if (is_negative !== head.neg)
          report_mismatch("is_negative", {63'd0, head.neg}, {63'd0, is_negative});
        kind_hits[head.kind]++;
      end
      results_seen++;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long receiver hold-off
        result_ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        hold_req = 1'b0;
      end else if (gaps_on) begin
        result_ready <= ($urandom_range(0, 99) >= 34);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run exceeded %0d cycles", CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [7:0] txt[$];
    value_rec_t row_want;
    int         base;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[r]) begin
      txt.delete();
      for (int k = 0; k < dir_rows[r].txt.len(); k++)
        txt.push_back((dir_rows[r].txt[k] == NUL_STAND_IN) ? CH_NUL : dir_rows[r].txt[k]);
      row_want = '{dir_rows[r].kind, dir_rows[r].mag, dir_rows[r].neg};
      send_text(txt, dir_rows[r].typed, row_want);
    end
    base = chars_sent;
    while (chars_sent < base + 120) begin
      build_text(txt);
      send_text(txt, 1'b0, '0);
    end
    hold_req = 1'b1;
    repeat (10) begin
      build_text(txt);
      send_text(txt, 1'b0, '0);
    end
    drain_results();
    gaps_on = 1'b0;
    while (chars_sent < base + 250) begin
      build_text(txt);
      send_text(txt, 1'b0, '0);
    end
    gaps_on = 1'b1;
    while (chars_sent < base + 390) begin
      build_text(txt);
      send_text(txt, 1'b0, '0);
    end
    drain_results();
    repeat (10) @(negedge clk);
    $display("%0d characters in %0d texts, %0d results checked", chars_sent, texts_sent,
             results_seen);
    $display("kinds seen: %0d string, %0d signed, %0d unsigned, %0d decimal",
             kind_hits[KIND_STRING], kind_hits[KIND_SIGNED], kind_hits[KIND_UNSIGNED],
             kind_hits[KIND_DECIMAL]);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[metric_text_number_classifier.f]
+incdir+rtl/core
rtl/core/mtnc_pkg.sv
rtl/core/mtnc_step.sv
rtl/core/mtnc_classify.sv
rtl/core/metric_text_number_classifier.sv
tb/tb_metric_text_number_classifier.sv
